[rtl/fbc_pkg.sv]
// fbc_pkg: shared types, constants and register codes for frustum_box_cull
// no dependencies; imported by every module of the block

package fbc_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int NUM_AXES    = 3;
    localparam int COORD_W     = 16;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int D_SHIFT     = 14;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int PART_W      = PROD_W + 1;
    localparam int SUM_W       = PART_W + 1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_TOP    = 3'd0,
        REG_PLANE_BOTTOM = 3'd1,
        REG_PLANE_RIGHT  = 3'd2,
        REG_PLANE_LEFT   = 3'd3,
        REG_PLANE_NEAR   = 3'd4,
        REG_PLANE_FAR    = 3'd5
    } cfg_reg_e;

    // d in bits 63:48, nz 47:32, ny 31:16, nx 15:0
    typedef struct packed {
        logic [COORD_W-1:0]               d;
        logic [NUM_AXES-1:0][COORD_W-1:0] n;
    } plane_t;

    typedef plane_t [NUM_PLANES-1:0] plane_set_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] hi;
        logic [NUM_AXES-1:0][COORD_W-1:0] lo;
    } box_t;

    // per plane: nx*px + ny*py and nz*pz + d, both Q.22
    typedef struct packed {
        logic [NUM_PLANES-1:0][PART_W-1:0] xy;
        logic [NUM_PLANES-1:0][PART_W-1:0] zd;
    } part_t;

endpackage

[rtl/fbc_front.sv]
// fbc_front: corner selection, products and partial sums for all planes
// two pipeline stages with per-stage ready; depends on fbc_pkg

module fbc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  fbc_pkg::plane_set_t planes,
    input  logic                in_valid,
    output logic                in_ready,
    input  fbc_pkg::box_t       in_box,
    output logic                out_valid,
    input  logic                out_ready,
    output fbc_pkg::part_t      out_part
);
    import fbc_pkg::*;

    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic                     s1_ready;
    logic                     s2_ready;
    logic [COORD_W-1:0]       corner    [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0] prod_next [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0] prod_reg  [NUM_PLANES][NUM_AXES];
    logic [COORD_W-1:0]       d_reg     [NUM_PLANES];
    part_t                    part_next;
    part_t                    part_reg;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_part  = part_reg;

    // positive vertex: max where the normal component is zero or above
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                corner[p][a] = planes[p].n[a][COORD_W-1] ? in_box.lo[a] : in_box.hi[a];
                prod_next[p][a] = $signed(planes[p].n[a]) * $signed(corner[p][a]);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            part_next.xy[p] = {prod_reg[p][0][PROD_W-1], prod_reg[p][0]}
                            + {prod_reg[p][1][PROD_W-1], prod_reg[p][1]};
            part_next.zd[p] = {prod_reg[p][2][PROD_W-1], prod_reg[p][2]}
                            + {{(PART_W-COORD_W-D_SHIFT){d_reg[p][COORD_W-1]}},
                               d_reg[p], D_SHIFT'(0)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            prod_reg <= prod_next;
            for (int p = 0; p < NUM_PLANES; p++) begin
                d_reg[p] <= planes[p].d;
            end
        end
        if (s2_ready && s1_valid_reg) begin
            part_reg <= part_next;
        end
    end

endmodule

[rtl/fbc_queue.sv]
// fbc_queue: short fifo of partial sums between front and back
// circular buffer with read/write pointers; depends on fbc_pkg

module fbc_queue #(
    parameter int DEPTH = fbc_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  fbc_pkg::part_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output fbc_pkg::part_t out_item
);
    import fbc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    part_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/fbc_back.sv]
// fbc_back: final plane distances, sign test and output register
// depends on fbc_pkg

module fbc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  fbc_pkg::part_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_visible
);
    import fbc_pkg::*;

    logic                  valid_reg;
    logic                  visible_reg;
    logic                  visible_next;
    logic [SUM_W-1:0]      plane_dist [NUM_PLANES];
    logic [NUM_PLANES-1:0] outside;

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_visible = visible_reg;

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            plane_dist[p] = {in_item.xy[p][PART_W-1], in_item.xy[p]}
                          + {in_item.zd[p][PART_W-1], in_item.zd[p]};
            outside[p] = plane_dist[p][SUM_W-1];
        end
        visible_next = ~|outside;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            visible_reg <= visible_next;
        end
    end

endmodule

[rtl/frustum_box_cull.sv]
// frustum_box_cull: box against six-plane frustum, positive-vertex test
// instantiates fbc_front, fbc_queue and fbc_back; depends on fbc_pkg

// Takes one axis-aligned box per cycle while s_ready is high and returns visible = 0
// when some plane puts the box's furthest corner along its normal at a negative
// distance. The accepting edge registers the eighteen corner products; the partial
// sums are then registered, written into the queue, and given the final add and
// sign test into the output register. The queue of QUEUE_DEPTH entries and the
// output register let the front keep taking boxes while results wait. Planes must
// be written through cfg_we/cfg_index only while no box is in flight; the block
// itself does not enforce this. Indexes past the far plane are ignored.

module frustum_box_cull #(
    parameter int QUEUE_DEPTH = fbc_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbc_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [fbc_pkg::COORD_W-1:0] s_min_x,
    input  logic signed [fbc_pkg::COORD_W-1:0] s_min_y,
    input  logic signed [fbc_pkg::COORD_W-1:0] s_min_z,
    input  logic signed [fbc_pkg::COORD_W-1:0] s_max_x,
    input  logic signed [fbc_pkg::COORD_W-1:0] s_max_y,
    input  logic signed [fbc_pkg::COORD_W-1:0] s_max_z,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_visible
);
    import fbc_pkg::*;

    plane_set_t planes_reg;
    box_t       box;
    logic       fq_valid;
    logic       fq_ready;
    part_t      fq_part;
    logic       qb_valid;
    logic       qb_ready;
    part_t      qb_part;

    assign box.lo[0] = s_min_x;
    assign box.lo[1] = s_min_y;
    assign box.lo[2] = s_min_z;
    assign box.hi[0] = s_max_x;
    assign box.hi[1] = s_max_y;
    assign box.hi[2] = s_max_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            planes_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PLANE_TOP:    planes_reg[0] <= plane_t'(cfg_wdata);
                REG_PLANE_BOTTOM: planes_reg[1] <= plane_t'(cfg_wdata);
                REG_PLANE_RIGHT:  planes_reg[2] <= plane_t'(cfg_wdata);
                REG_PLANE_LEFT:   planes_reg[3] <= plane_t'(cfg_wdata);
                REG_PLANE_NEAR:   planes_reg[4] <= plane_t'(cfg_wdata);
                REG_PLANE_FAR:    planes_reg[5] <= plane_t'(cfg_wdata);
                default: ;
            endcase
        end
    end

    fbc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .planes    (planes_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_box    (box),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_part  (fq_part)
    );

    fbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_part),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_part)
    );

    fbc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (qb_valid),
        .in_ready    (qb_ready),
        .in_item     (qb_part),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_visible (m_visible)
    );

endmodule

[rtl/fbc_checker.sv]
// fbc_checker: port-level checks on item flow through frustum_box_cull
// bound to the top level below; depends on fbc_pkg

module fbc_checker #(
    parameter int QUEUE_DEPTH = fbc_pkg::QUEUE_DEPTH
) (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_visible
);
    import fbc_pkg::*;

    // two front stages, the queue and the output register
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 3;
    localparam int CNT_W        = $clog2(MAX_INFLIGHT + 1) + 1;

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_visible))
        else $error("result changed while stalled");

    // no result without an accepted box
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("result with no box in flight");

    // in-flight boxes bounded by pipeline capacity
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(MAX_INFLIGHT))
        else $error("more boxes in flight than storage");

    // empty block always takes a box
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == '0 |-> s_ready)
        else $error("empty block not ready");

endmodule

bind frustum_box_cull fbc_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fbc_checker (.*);
